FILE: hw/rtl/swp_pkg.sv
// Types and codes shared by the skin weight packer RTL and its testbench.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package swp_pkg;

   localparam int SLOT_NUM = 4;

   typedef enum logic [1:0] {
      REQ_CLEAR    = 2'd0,
      REQ_ADD      = 2'd1,
      REQ_FINALIZE = 2'd2,
      REQ_NONE     = 2'd3
   } req_code_type;

   typedef struct packed {
      logic [7:0]  bone;
      logic [15:0] weight;
   } slot_type;

   typedef slot_type [SLOT_NUM-1:0] row_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

FILE: hw/rtl/swp_ifs.sv
// Channel interfaces of the skin weight packer: request, response, config write.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface swp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [11:0] vertex_id;
   logic        bone_found;
   logic [9:0]  bone_index;
   logic [15:0] weight;
   modport source (output valid, req_type, vertex_id, bone_found, bone_index, weight,
                   input ready);
   modport sink   (input valid, req_type, vertex_id, bone_found, bone_index, weight,
                   output ready);
endinterface

interface swp_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] out_vertex;
   logic [7:0]  index_0;
   logic [7:0]  index_1;
   logic [7:0]  index_2;
   logic [7:0]  index_3;
   logic [15:0] norm_weight_0;
   logic [15:0] norm_weight_1;
   logic [15:0] norm_weight_2;
   logic [15:0] norm_weight_3;
   modport source (output valid, out_vertex, index_0, index_1, index_2, index_3,
                   norm_weight_0, norm_weight_1, norm_weight_2, norm_weight_3,
                   input ready);
   modport sink   (input valid, out_vertex, index_0, index_1, index_2, index_3,
                   norm_weight_0, norm_weight_1, norm_weight_2, norm_weight_3,
                   output ready);
endinterface

interface swp_csr_if;
   logic        valid;
   logic        ready;
   logic [12:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/skin_weight_packer.sv
// Skin weight packer top level: per-vertex four-slot bone store with normalize.
// Depends on swp_pkg and the channel interfaces in swp_ifs.sv.
//
// Usage: req carries clear / add / finalize transactions for one vertex. Each
// vertex row (four bone/weight slots) lives in one synchronous RAM row. A
// transaction is accepted in idle, the row is read, and in the next cycle
// clear or add writes it back. Finalize sums the row and runs four bit-serial
// dividers in parallel (16 steps), then loads the rsp output register; the
// next req is accepted only after that load. Out-of-range vertices and the
// unused request code are accepted in idle and produce nothing.
// csr writes vertex_count and is always ready; write it only while idle.
// Reset clears control and vertex_count; RAM contents stay undefined until
// cleared or written. A stalled rsp holds its output register; req stays
// accepted while a result waits, and a second finalize waits in ST_DONE
// until the first result is taken.
`timescale 1ns / 1ps
`default_nettype none
module skin_weight_packer
   import swp_pkg::*;
#(
   parameter int VERTEX_DEPTH = 4096,
   parameter int BONE_LIMIT   = 256
) (
   input  wire logic  clock,
   input  wire logic  reset,
   swp_req_if.sink    req,
   swp_rsp_if.source  rsp,
   swp_csr_if.sink    csr
);

   localparam int AW = $clog2(VERTEX_DEPTH);

   state_type   state_ff, state_in;
   logic [12:0] vcount_ff;
   row_type     mem [VERTEX_DEPTH];
   row_type     rd_row_ff;
   logic [AW-1:0] addr_ff;
   logic [1:0]  op_ff;
   logic [11:0] vid_ff;
   logic [7:0]  bone_ff;
   logic [15:0] w_ff;
   logic        add_ok_ff;

   logic [17:0] sum_ff;
   logic [17:0] rem_ff [SLOT_NUM];
   logic [15:0] num_ff [SLOT_NUM];
   logic [15:0] quo_ff [SLOT_NUM];
   logic [7:0]  bones_ff [SLOT_NUM];
   logic [3:0]  cnt_ff;

   logic        rsp_valid_ff;
   logic [11:0] rsp_vid_ff;
   logic [7:0]  rsp_idx_ff [SLOT_NUM];
   logic [15:0] rsp_w_ff [SLOT_NUM];

   logic        accept, in_range, go, wr_en, load_out;
   logic [16:0] vid_ext;
   row_type     wr_row;

   assign csr.ready = 1'b1;
   assign accept    = req.valid && req.ready;
   assign vid_ext   = 17'(req.vertex_id);
   assign in_range  = ({1'b0, req.vertex_id} < vcount_ff) &&
                      (32'(req.vertex_id) < VERTEX_DEPTH);
   assign go        = in_range && (req.req_type != REQ_NONE);
   assign load_out  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp.ready);

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= '0;
      end else if (csr.valid && csr.ready) begin
         vcount_ff <= csr.data;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept && go) state_in = ST_READ;
         ST_READ: if (op_ff == REQ_FINALIZE) state_in = ST_DIV;
                  else state_in = ST_IDLE;
         ST_DIV:  if (cnt_ff == 4'd15) state_in = ST_DONE;
         ST_DONE: if (load_out) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the control
   always_comb begin
      req.ready = (state_ff == ST_IDLE);
      wr_en     = (state_ff == ST_READ) &&
                  ((op_ff == REQ_CLEAR) || (op_ff == REQ_ADD && add_ok_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // request capture and row read
   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff   <= vid_ext[AW-1:0];
         op_ff     <= req.req_type;
         vid_ff    <= req.vertex_id;
         bone_ff   <= req.bone_index[7:0];
         w_ff      <= req.weight;
         add_ok_ff <= req.bone_found && (32'(req.bone_index) < BONE_LIMIT);
         rd_row_ff <= mem[vid_ext[AW-1:0]];
      end
   end

   // add / clear modify of the row read back
   always_comb begin
      logic        found_zero;
      logic [1:0]  pick;
      logic [1:0]  low;
      found_zero = 1'b0;
      pick       = '0;
      low        = '0;
      for (int i = SLOT_NUM-1; i >= 0; i--) begin
         if (rd_row_ff[i].weight == 16'd0) begin
            found_zero = 1'b1;
            pick       = 2'(i);
         end
      end
      for (int i = 1; i < SLOT_NUM; i++) begin
         if (rd_row_ff[i].weight < rd_row_ff[low].weight) low = 2'(i);
      end
      wr_row = rd_row_ff;
      if (op_ff == REQ_CLEAR) begin
         wr_row = '0;
      end else if (found_zero) begin
         wr_row[pick].bone   = bone_ff;
         wr_row[pick].weight = w_ff;
      end else if (w_ff > rd_row_ff[low].weight) begin
         wr_row[low].bone   = bone_ff;
         wr_row[low].weight = w_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[addr_ff] <= wr_row;
   end

   // bit-serial dividers, one lane per slot: w*65535 / sum
   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         sum_ff <= 18'(rd_row_ff[0].weight) + 18'(rd_row_ff[1].weight) +
                   18'(rd_row_ff[2].weight) + 18'(rd_row_ff[3].weight);
         cnt_ff <= '0;
         for (int i = 0; i < SLOT_NUM; i++) begin
            logic [31:0] n;
            n = {rd_row_ff[i].weight, 16'd0} - 32'(rd_row_ff[i].weight);
            rem_ff[i]   <= 18'(n[31:16]);
            num_ff[i]   <= n[15:0];
            quo_ff[i]   <= '0;
            bones_ff[i] <= rd_row_ff[i].bone;
         end
      end else if (state_ff == ST_DIV) begin
         cnt_ff <= cnt_ff + 4'd1;
         for (int i = 0; i < SLOT_NUM; i++) begin
            logic [18:0] t;
            t = {rem_ff[i], num_ff[i][15]};
            num_ff[i] <= {num_ff[i][14:0], 1'b0};
            if (t >= 19'(sum_ff)) begin
               rem_ff[i] <= 18'(t - 19'(sum_ff));
               quo_ff[i] <= {quo_ff[i][14:0], 1'b1};
            end else begin
               rem_ff[i] <= t[17:0];
               quo_ff[i] <= {quo_ff[i][14:0], 1'b0};
            end
         end
      end
   end

   // response output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_vid_ff <= vid_ff;
         for (int i = 0; i < SLOT_NUM; i++) begin
            rsp_idx_ff[i] <= bones_ff[i];
            rsp_w_ff[i]   <= (sum_ff == 18'd0) ? 16'd0 : quo_ff[i];
         end
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.out_vertex    = rsp_vid_ff;
   assign rsp.index_0       = rsp_idx_ff[0];
   assign rsp.index_1       = rsp_idx_ff[1];
   assign rsp.index_2       = rsp_idx_ff[2];
   assign rsp.index_3       = rsp_idx_ff[3];
   assign rsp.norm_weight_0 = rsp_w_ff[0];
   assign rsp.norm_weight_1 = rsp_w_ff[1];
   assign rsp.norm_weight_2 = rsp_w_ff[2];
   assign rsp.norm_weight_3 = rsp_w_ff[3];

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Testbench for skin_weight_packer: directed table plus random transactions,
// checked against an in-bench model of the four-slot bone store.
// Depends on swp_pkg, swp_ifs.sv and the skin_weight_packer RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_top
   import swp_pkg::*;
();

   localparam int VDEPTH  = 4096;
   localparam int BLIMIT  = 256;
   localparam int NRAND   = 500;

   typedef struct packed {
      logic [11:0] vtx;
      logic [7:0]  idx0, idx1, idx2, idx3;
      logic [15:0] nw0, nw1, nw2, nw3;
   } vertex_out_type;

   typedef struct {
      req_code_type   op;
      logic [11:0]    vid;
      logic           found;
      logic [9:0]     bone;
      logic [15:0]    w;
      logic           has_exp;
      vertex_out_type exp;
   } dir_row_type;

   logic clock;
   logic reset;

   swp_req_if req ();
   swp_rsp_if rsp ();
   swp_csr_if csr ();

   skin_weight_packer #(.VERTEX_DEPTH(VDEPTH), .BONE_LIMIT(BLIMIT)) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   // model state
   logic [12:0] mdl_vcount;
   logic [7:0]  mdl_bone   [VDEPTH][SLOT_NUM];
   logic [15:0] mdl_weight [VDEPTH][SLOT_NUM];
   bit          cleared    [VDEPTH];

   vertex_out_type pending_vertices[$];
   int          errors;
   bit          rsp_idle_on;
   bit          req_idle_on;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("[skin_weight_packer] ERROR");
      $finish;
   end

   // apply one transaction to the model; returns 1 with a finalized row
   function automatic bit model_apply(req_code_type op, logic [11:0] vid, logic found,
                                      logic [9:0] bone, logic [15:0] w,
                                      output vertex_out_type res);
      int pick;
      int low;
      logic [17:0] sum;
      logic [15:0] nw[SLOT_NUM];
      res = '0;
      if (vid >= mdl_vcount || vid >= VDEPTH) return 0;
      case (op)
         REQ_CLEAR: begin
            for (int i = 0; i < SLOT_NUM; i++) begin
               mdl_bone[vid][i]   = '0;
               mdl_weight[vid][i] = '0;
            end
            cleared[vid] = 1;
         end
         REQ_ADD: begin
            if (found && bone < BLIMIT) begin
               pick = -1;
               for (int i = SLOT_NUM - 1; i >= 0; i--)
                  if (mdl_weight[vid][i] == 0) pick = i;
               if (pick < 0) begin
                  low = 0;
                  for (int i = 1; i < SLOT_NUM; i++)
                     if (mdl_weight[vid][i] < mdl_weight[vid][low]) low = i;
                  if (w > mdl_weight[vid][low]) pick = low;
               end
               if (pick >= 0) begin
                  mdl_bone[vid][pick]   = bone[7:0];
                  mdl_weight[vid][pick] = w;
               end
            end
         end
         REQ_FINALIZE: begin
            sum = '0;
            for (int i = 0; i < SLOT_NUM; i++) sum += mdl_weight[vid][i];
            for (int i = 0; i < SLOT_NUM; i++)
               nw[i] = (sum == 0) ? 16'd0 :
                       16'(({18'd0, mdl_weight[vid][i]} * 34'd65535) / sum);
            res = '{vid, mdl_bone[vid][0], mdl_bone[vid][1], mdl_bone[vid][2],
                    mdl_bone[vid][3], nw[0], nw[1], nw[2], nw[3]};
            return 1;
         end
         default: ;
      endcase
      return 0;
   endfunction

   // idle draw: about 37 in 100 unless a no-idle stretch is on
   function automatic bit idle_draw(bit enabled);
      return enabled && ($urandom_range(99) < 37);
   endfunction

   // valid stays high after an accept so back-to-back calls keep the channel busy;
   // it drops only on an idle cycle or before a wait outside this task
   task automatic send_req(req_code_type op, logic [11:0] vid, logic found,
                           logic [9:0] bone, logic [15:0] w,
                           bit has_exp, vertex_out_type exp_row);
      vertex_out_type pred;
      bit got;
      while (idle_draw(req_idle_on)) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid      <= 1'b1;
      req.req_type   <= op;
      req.vertex_id  <= vid;
      req.bone_found <= found;
      req.bone_index <= bone;
      req.weight     <= w;
      do @(posedge clock); while (!req.ready);
      got = model_apply(op, vid, found, bone, w, pred);
      if (got) begin
         if (has_exp && pred !== exp_row) begin
            errors++;
            if (errors <= 10)
               $display("table row disagrees with model: table %h model %h", exp_row, pred);
         end
         pending_vertices.push_back(pred);
      end
   endtask

   task automatic write_vcount(logic [12:0] val);
      req.valid <= 1'b0;
      while (pending_vertices.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
      csr.valid <= 1'b1;
      csr.data  <= val;
      do @(posedge clock); while (!csr.ready);
      csr.valid  <= 1'b0;
      mdl_vcount = val;
   endtask

   // clear every vertex below count that was never cleared
   task automatic clear_range(int cnt);
      for (int v = 0; v < cnt; v++)
         if (!cleared[v]) send_req(REQ_CLEAR, 12'(v), 1'b0, '0, '0, 1'b0, '0);
   endtask

   // random transaction on a cleared vertex, a clear, or out of range
   task automatic random_req(int cnt);
      req_code_type op;
      int sel;
      logic [11:0] vid;
      sel = $urandom_range(99);
      if (sel < 50)       op = REQ_ADD;
      else if (sel < 75)  op = REQ_FINALIZE;
      else if (sel < 88)  op = REQ_CLEAR;
      else                op = REQ_NONE;
      if ($urandom_range(9) == 0) vid = 12'($urandom_range(4095));
      else                        vid = 12'($urandom_range(cnt - 1));
      // never read or touch a row that was never cleared
      if (vid < mdl_vcount && !cleared[vid] && op != REQ_CLEAR) vid = 12'(mdl_vcount);
      if (vid >= mdl_vcount && mdl_vcount == VDEPTH) vid = 0;
      send_req(op, vid, $urandom_range(15) != 0,
               ($urandom_range(7) == 0) ? 10'($urandom) : 10'($urandom_range(BLIMIT - 1)),
               ($urandom_range(5) == 0) ? 16'($urandom_range(3)) : 16'($urandom),
               1'b0, '0);
   endtask

   // response checker
   always @(posedge clock) begin
      vertex_out_type got;
      vertex_out_type want;
      if (!reset) begin
         rsp.ready <= !idle_draw(rsp_idle_on);
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.out_vertex, rsp.index_0, rsp.index_1, rsp.index_2, rsp.index_3,
                    rsp.norm_weight_0, rsp.norm_weight_1, rsp.norm_weight_2,
                    rsp.norm_weight_3};
            if (pending_vertices.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected transaction %h", got);
            end else begin
               want = pending_vertices.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10) $display("mismatch: expected %h actual %h", want, got);
               end
            end
         end
      end
   end

   // stimulus
   initial begin
      dir_row_type rows[$];
      vertex_out_type e;
      reset       = 1'b1;
      req.valid   = 1'b0;
      req.req_type = REQ_CLEAR;
      req.vertex_id = '0;
      req.bone_found = 1'b0;
      req.bone_index = '0;
      req.weight  = '0;
      rsp.ready   = 1'b0;
      csr.valid   = 1'b0;
      csr.data    = '0;
      errors      = 0;
      rsp_idle_on = 1;
      req_idle_on = 1;
      mdl_vcount  = '0;
      foreach (cleared[i]) cleared[i] = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // count zero: everything ignored
      send_req(REQ_FINALIZE, '0, 1'b0, '0, '0, 1'b0, '0);
      send_req(REQ_CLEAR, '0, 1'b0, '0, '0, 1'b0, '0);
      write_vcount(13'd8);
      clear_range(8);
      e = '0;
      rows = '{
         '{REQ_FINALIZE, 12'd0, 1'b0, 10'd0, 16'd0, 1'b1, e},           // zero sum
         '{REQ_ADD, 12'd1, 1'b1, 10'd255, 16'hFFFF, 1'b0, e},
         '{REQ_FINALIZE, 12'd1, 1'b0, 10'd0, 16'd0, 1'b1,
           '{12'd1, 8'd255, 8'd0, 8'd0, 8'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0}},
         '{REQ_ADD, 12'd2, 1'b1, 10'd7, 16'd0, 1'b0, e},                  // zero weight
         '{REQ_ADD, 12'd2, 1'b0, 10'd9, 16'd100, 1'b0, e},                // not found
         '{REQ_ADD, 12'd2, 1'b1, 10'd256, 16'd100, 1'b0, e},              // bone limit
         '{REQ_ADD, 12'd2, 1'b1, 10'd1023, 16'd100, 1'b0, e},
         '{REQ_FINALIZE, 12'd2, 1'b0, 10'd0, 16'd0, 1'b1,
           '{12'd2, 8'd7, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0}},
         '{REQ_ADD, 12'd3, 1'b1, 10'd1, 16'd10, 1'b0, e},
         '{REQ_ADD, 12'd3, 1'b1, 10'd2, 16'd20, 1'b0, e},
         '{REQ_ADD, 12'd3, 1'b1, 10'd3, 16'd30, 1'b0, e},
         '{REQ_ADD, 12'd3, 1'b1, 10'd4, 16'd40, 1'b0, e},
         '{REQ_ADD, 12'd3, 1'b1, 10'd5, 16'd10, 1'b0, e},                 // not larger
         '{REQ_ADD, 12'd3, 1'b1, 10'd6, 16'd11, 1'b0, e},                 // replaces min
         '{REQ_FINALIZE, 12'd3, 1'b0, 10'd0, 16'd0, 1'b0, e},
         '{REQ_NONE, 12'd3, 1'b1, 10'd0, 16'd5, 1'b0, e},
         '{REQ_FINALIZE, 12'd8, 1'b0, 10'd0, 16'd0, 1'b0, e},             // out of range
         '{REQ_ADD, 12'd4095, 1'b1, 10'd0, 16'd5, 1'b0, e},
         '{REQ_CLEAR, 12'd3, 1'b0, 10'd0, 16'd0, 1'b0, e},
         '{REQ_FINALIZE, 12'd3, 1'b0, 10'd0, 16'd0, 1'b1,
           '{12'd3, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0}}
      };
      e.vtx = 12'd0;
      rows[0].exp = e;
      foreach (rows[i])
         send_req(rows[i].op, rows[i].vid, rows[i].found, rows[i].bone, rows[i].w,
                  rows[i].has_exp, rows[i].exp);

      // random phases at several counts, last one at the maximum
      for (int ph = 0; ph < 4; ph++) begin
         int cnt;
         case (ph)
            0: cnt = 1;
            1: cnt = 16;
            2: cnt = 5;
            default: cnt = VDEPTH;
         endcase
         write_vcount(13'(cnt));
         if (ph < 3) clear_range(cnt);
         else clear_range(24);
         req_idle_on = (ph != 1);
         rsp_idle_on = (ph != 1);
         for (int n = 0; n < NRAND / 4; n++)
            random_req((ph == 3) ? 24 : cnt);
         req_idle_on = 1;
         rsp_idle_on = 1;
      end
      // one vertex at the top of the range
      clear_range(1);
      send_req(REQ_CLEAR, 12'd4095, 1'b0, '0, '0, 1'b0, '0);
      send_req(REQ_ADD, 12'd4095, 1'b1, 10'd255, 16'hFFFF, 1'b0, '0);
      send_req(REQ_FINALIZE, 12'd4095, 1'b0, '0, '0, 1'b0, '0);
      write_vcount(13'd0);

      while (pending_vertices.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("[skin_weight_packer] OK");
      end else begin
         $display("[skin_weight_packer] ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
